// ===== hw/rtl/rpr_pkg.sv =====
package rpr_pkg;

  // field widths
  localparam int POS_W   = 16;
  localparam int PAIR_W  = 8;
  localparam int VAL_W   = 32;
  localparam int BASE_W  = 24;
  localparam int DIM_W   = 10;
  localparam int FREQ_W  = 31;
  localparam int F4_W    = FREQ_W + 2;
  localparam int ACC_W   = 35;
  localparam int T_W     = 37;
  localparam int XY_W    = 42;
  localparam int Z_W     = 20;
  localparam int CORDIC_STEPS = 16;

  // angle constants in q32 radians
  localparam logic [ACC_W-1:0]      TWO_PI_Q32  = 35'h6487ED511;
  localparam logic [ACC_W:0]        FOUR_PI_Q32 = 36'hC90FDAA22;
  localparam logic signed [T_W-1:0] TWO_PI_T    = 37'sh6487ED511;
  localparam logic signed [T_W-1:0] PI_T        = 37'sh3243F6A88;
  localparam logic signed [T_W-1:0] HALF_PI_T   = 37'sh1921FB544;

  // inverse cordic gain in q30
  localparam logic signed [VAL_W-1:0] INV_GAIN_Q30 = 32'sd652032874;

  // configuration register indexes
  localparam logic REG_ROPE_BASE   = 1'b0;
  localparam logic REG_ROTATED_DIM = 1'b1;

  // word handed along the angle cells
  typedef struct packed {
    logic [POS_W-1:0]        pos;
    logic [ACC_W-1:0]        acc;
    logic [F4_W-1:0]         f4;
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
  } ang_t;

  // word handed along the rotation cells
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } rot_t;

  // arctangent of 2^-i in q16 radians
  function automatic logic signed [Z_W-1:0] atan_q16(input logic [3:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      4'd0:  v = 20'sd51472;
      4'd1:  v = 20'sd30386;
      4'd2:  v = 20'sd16055;
      4'd3:  v = 20'sd8150;
      4'd4:  v = 20'sd4091;
      4'd5:  v = 20'sd2047;
      4'd6:  v = 20'sd1024;
      4'd7:  v = 20'sd512;
      4'd8:  v = 20'sd256;
      4'd9:  v = 20'sd128;
      4'd10: v = 20'sd64;
      4'd11: v = 20'sd32;
      4'd12: v = 20'sd16;
      4'd13: v = 20'sd8;
      4'd14: v = 20'sd4;
      default: v = 20'sd2;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/rpr_freq_table.sv =====
module rpr_freq_table import rpr_pkg::*; #(
  parameter int PAIR_DEPTH = 256,
  parameter int IDX_W      = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [BASE_W-1:0] rope_base_i,
  input  logic [DIM_W-1:0]  rotated_dim_i,
  input  logic              rd_en_i,
  input  logic [IDX_W-1:0]  rd_addr_i,
  output logic [FREQ_W-1:0] rd_data_o,
  output logic              ready_o
);

  typedef enum logic [2:0] {
    S_LOG_INIT, S_LOG, S_DIV, S_EXP_BIT, S_SQRT, S_STORE, S_DONE
  } state_e;

  state_e            state_q;
  logic [4:0]        cnt_q;
  logic [4:0]        exp_q;
  logic [23:0]       frac_q;
  logic [31:0]       m_q;
  logic [29:0]       div_q;
  logic [DIM_W-1:0]  rem_q;
  logic [38:0]       ex_q;
  logic [DIM_W-1:0]  exr_q;
  logic [IDX_W-1:0]  d_q;
  logic [30:0]       r_q;
  logic [61:0]       v_q;
  logic [61:0]       res_q;
  logic [61:0]       bit_q;
  logic [FREQ_W-1:0] mem_q [PAIR_DEPTH];
  logic [FREQ_W-1:0] rd_q;

  logic [DIM_W-1:0]  dim_eff;
  logic [4:0]        msb;
  logic [31:0]       m_init;
  logic [63:0]       sq;
  logic [32:0]       sq_sh;
  logic [DIM_W:0]    rem_sh;
  logic              rem_ge;
  logic [DIM_W:0]    exr_sum;
  logic [23:0]       ex_fp;
  logic [30:0]       r_pre;
  logic [61:0]       sq_sum;
  logic [61:0]       res_n;
  logic [14:0]       ip;
  logic [FREQ_W-1:0] freq_w;

  // msb of the base and first mantissa
  always_comb begin
    msb = '0;
    for (int i = 0; i < BASE_W; i++) begin
      if (rope_base_i[i]) msb = 5'(i);
    end
    m_init = 32'(rope_base_i) << (5'd31 - msb);
  end

  // datapath of the build pass
  always_comb begin
    dim_eff = (rotated_dim_i == '0) ? DIM_W'(1) : rotated_dim_i;
    sq      = 64'(m_q) * 64'(m_q);
    sq_sh   = sq[63:31];
    rem_sh  = {rem_q, div_q[29]};
    rem_ge  = rem_sh >= {1'b0, dim_eff};
    exr_sum = {1'b0, exr_q} + {1'b0, rem_q};
    ex_fp   = ex_q[23:0];
    r_pre   = ex_fp[cnt_q] ? (r_q >> 1) : r_q;
    sq_sum  = res_q + bit_q;
    res_n   = (v_q >= sq_sum) ? ((res_q >> 1) + bit_q) : (res_q >> 1);
    ip      = ex_q[38:24];
    freq_w  = (ip >= 15'd31) ? '0 : (r_q >> ip[4:0]);
  end

  // build sequencer: log2, divide, then one exp2 per entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOG_INIT;
      cnt_q   <= '0;
    end else if (start_i) begin
      state_q <= S_LOG_INIT;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_LOG_INIT: begin
          cnt_q  <= '0;
          frac_q <= '0;
          if (rope_base_i <= BASE_W'(1)) begin
            exp_q   <= '0;
            div_q   <= '0;
            rem_q   <= '0;
            state_q <= S_DIV;
          end else begin
            exp_q   <= msb;
            m_q     <= m_init;
            state_q <= S_LOG;
          end
        end
        S_LOG: begin
          frac_q <= {frac_q[22:0], sq_sh[32]};
          m_q    <= sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
          if (cnt_q == 5'd23) begin
            cnt_q   <= '0;
            div_q   <= {exp_q, frac_q[22:0], sq_sh[32], 1'b0};
            rem_q   <= '0;
            state_q <= S_DIV;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        S_DIV: begin
          div_q <= {div_q[28:0], rem_ge};
          rem_q <= rem_ge ? DIM_W'(rem_sh - {1'b0, dim_eff}) : rem_sh[DIM_W-1:0];
          if (cnt_q == 5'd29) begin
            cnt_q   <= '0;
            ex_q    <= '0;
            exr_q   <= '0;
            d_q     <= '0;
            r_q     <= 31'd1 << 30;
            state_q <= S_EXP_BIT;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        S_EXP_BIT: begin
          v_q     <= 62'(r_pre) << 30;
          res_q   <= '0;
          bit_q   <= 62'd1 << 60;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          if (v_q >= sq_sum) v_q <= v_q - sq_sum;
          res_q <= res_n;
          bit_q <= bit_q >> 2;
          if (bit_q == 62'd1) begin
            r_q <= res_n[30:0];
            if (cnt_q == 5'd23) begin
              state_q <= S_STORE;
            end else begin
              cnt_q   <= cnt_q + 5'd1;
              state_q <= S_EXP_BIT;
            end
          end
        end
        S_STORE: begin
          if (d_q == IDX_W'(PAIR_DEPTH - 1)) begin
            state_q <= S_DONE;
          end else begin
            d_q   <= d_q + IDX_W'(1);
            cnt_q <= '0;
            r_q   <= 31'd1 << 30;
            if (exr_sum >= {1'b0, dim_eff}) begin
              exr_q <= DIM_W'(exr_sum - {1'b0, dim_eff});
              ex_q  <= ex_q + 39'(div_q) + 39'd1;
            end else begin
              exr_q <= exr_sum[DIM_W-1:0];
              ex_q  <= ex_q + 39'(div_q);
            end
            state_q <= S_EXP_BIT;
          end
        end
        S_DONE: begin
          state_q <= S_DONE;
        end
        default: state_q <= S_LOG_INIT;
      endcase
    end
  end

  // frequency memory
  always_ff @(posedge clk_i) begin
    if (state_q == S_STORE) mem_q[d_q] <= freq_w;
    if (rd_en_i) rd_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_q;
  assign ready_o   = (state_q == S_DONE);

endmodule

// ===== hw/rtl/rpr_angle_cell.sv =====
module rpr_angle_cell import rpr_pkg::*; #(
  parameter int BIT_SEL = 15
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic vld_i,
  input  ang_t word_i,
  output logic vld_o,
  output ang_t word_o
);

  logic [T_W-1:0]   dbl;
  logic [ACC_W-1:0] acc_d;
  ang_t             word_d;
  logic             vld_q;
  ang_t             word_q;

  // horner step: twice the angle plus this bit's share, mod 2*pi
  always_comb begin
    dbl = {1'b0, word_i.acc, 1'b0}
        + (word_i.pos[BIT_SEL] ? T_W'(word_i.f4) : '0);
    if (dbl >= T_W'(FOUR_PI_Q32)) begin
      acc_d = ACC_W'(dbl - T_W'(FOUR_PI_Q32));
    end else if (dbl >= T_W'(TWO_PI_Q32)) begin
      acc_d = ACC_W'(dbl - T_W'(TWO_PI_Q32));
    end else begin
      acc_d = dbl[ACC_W-1:0];
    end
    word_d     = word_i;
    word_d.acc = acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign vld_o  = vld_q;
  assign word_o = word_q;

endmodule

// ===== hw/rtl/rpr_cordic_cell.sv =====
module rpr_cordic_cell import rpr_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic vld_i,
  input  rot_t word_i,
  output logic vld_o,
  output rot_t word_o
);

  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  rot_t                   word_d;
  logic                   vld_q;
  rot_t                   word_q;

  // one micro-rotation toward zero residual angle
  always_comb begin
    xs = word_i.x >>> STEP;
    ys = word_i.y >>> STEP;
    if (word_i.z >= 0) begin
      word_d.x = word_i.x - ys;
      word_d.y = word_i.y + xs;
      word_d.z = word_i.z - atan_q16(4'(STEP));
    end else begin
      word_d.x = word_i.x + ys;
      word_d.y = word_i.y - xs;
      word_d.z = word_i.z + atan_q16(4'(STEP));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) word_q <= word_d;
  end

  assign vld_o  = vld_q;
  assign word_o = word_q;

endmodule

// ===== hw/rtl/rotary_position_rotate_unit.sv =====
// Rotary position embedding on one value pair per word. A word carries a token
// position, a pair index and two Q16.16 values; the result is the pair rotated
// by position * base^(-2d/dim), saturated to Q16.16. Throughput is one word per
// clock while the table is ready and m_axis_tready does not hold the output;
// each word passes one frequency table read, 16 angle cells (one position bit
// each, mod 2*pi), three fold/scale stages, 16 CORDIC cells and the output
// register. The per-pair frequencies sit in a table of min(MAX_PAIRS,256)
// entries that is rebuilt after reset and after every configuration write by a
// sequencer with one squaring, one divide step or one square-root digit per
// cycle; s_axis_tready stays low meanwhile. Pair indexes wrap modulo MAX_PAIRS.
module rotary_position_rotate_unit import rpr_pkg::*; #(
  parameter int MAX_PAIRS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // position, pair_index, first_value, second_value
  input  logic [87:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // rotated_first, rotated_second
  output logic [63:0] m_axis_tdata
);

  localparam int PAIR_DEPTH = (MAX_PAIRS < 256) ? MAX_PAIRS : 256;
  localparam int IDX_W      = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
  localparam logic signed [Z_W-1:0] Z_LIMIT = 20'sd102944;

  logic [BASE_W-1:0] rope_base_q;
  logic [DIM_W-1:0]  rotated_dim_q;
  logic              tbl_ready;
  logic              pipe_en;
  logic              accept;
  logic [16:0]       pair_rem;
  logic [FREQ_W-1:0] freq;

  logic                    vld0_q;
  logic [POS_W-1:0]        pos0_q;
  logic signed [VAL_W-1:0] a0_q;
  logic signed [VAL_W-1:0] b0_q;

  logic avld [POS_W+1];
  ang_t aw   [POS_W+1];

  logic                    fa_vld_q;
  logic signed [T_W-1:0]   fa_t_q;
  logic signed [63:0]      fa_pa_q;
  logic signed [63:0]      fa_pb_q;
  logic signed [T_W-1:0]   t0;
  logic signed [T_W-1:0]   t1;

  logic                    fb_vld_q;
  logic signed [T_W-1:0]   fb_t_q;
  logic                    fb_neg_q;
  logic signed [XY_W-1:0]  fb_x_q;
  logic signed [XY_W-1:0]  fb_y_q;
  logic signed [T_W-1:0]   t_abs;
  logic signed [T_W-1:0]   t_rnd;

  logic rvld [CORDIC_STEPS+1];
  rot_t rw   [CORDIC_STEPS+1];

  logic              out_vld_q;
  logic [VAL_W-1:0]  out_first_q;
  logic [VAL_W-1:0]  out_second_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rope_base_q   <= BASE_W'(10000);
      rotated_dim_q <= DIM_W'(128);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROPE_BASE:   rope_base_q   <= cfg_wdata_i;
        REG_ROTATED_DIM: rotated_dim_q <= cfg_wdata_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: the whole row moves unless the output word is stuck
  assign pipe_en       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = pipe_en && tbl_ready && !cfg_we_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // pair index modulo MAX_PAIRS by restoring subtraction
  always_comb begin
    pair_rem = 17'(s_axis_tdata[23:16]);
    for (int k = PAIR_W - 1; k >= 0; k--) begin
      if (pair_rem >= (17'(MAX_PAIRS) << k)) pair_rem = pair_rem - (17'(MAX_PAIRS) << k);
    end
  end

  rpr_freq_table #(
    .PAIR_DEPTH (PAIR_DEPTH),
    .IDX_W      (IDX_W)
  ) u_freq_table (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (cfg_we_i),
    .rope_base_i   (rope_base_q),
    .rotated_dim_i (rotated_dim_q),
    .rd_en_i       (pipe_en),
    .rd_addr_i     (pair_rem[IDX_W-1:0]),
    .rd_data_o     (freq),
    .ready_o       (tbl_ready)
  );

  // input stage alongside the table read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (pipe_en) begin
      vld0_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      pos0_q <= s_axis_tdata[15:0];
      a0_q   <= s_axis_tdata[55:24];
      b0_q   <= s_axis_tdata[87:56];
    end
  end

  // angle cells, most significant position bit first
  assign avld[0]   = vld0_q;
  assign aw[0].pos = pos0_q;
  assign aw[0].acc = '0;
  assign aw[0].f4  = {freq, 2'b00};
  assign aw[0].a   = a0_q;
  assign aw[0].b   = b0_q;

  for (genvar i = 0; i < POS_W; i++) begin : g_angle
    rpr_angle_cell #(.BIT_SEL(POS_W - 1 - i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (pipe_en),
      .vld_i  (avld[i]),
      .word_i (aw[i]),
      .vld_o  (avld[i+1]),
      .word_o (aw[i+1])
    );
  end

  // fold to (-pi, pi] and scale by the inverse gain
  assign t0 = $signed({2'b00, aw[POS_W].acc});
  assign t1 = (t0 > PI_T) ? (t0 - TWO_PI_T) : t0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fa_vld_q <= 1'b0;
      fb_vld_q <= 1'b0;
      rvld[0]  <= 1'b0;
    end else if (pipe_en) begin
      fa_vld_q <= avld[POS_W];
      fb_vld_q <= fa_vld_q;
      rvld[0]  <= fb_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      fa_t_q  <= t1;
      fa_pa_q <= 64'(aw[POS_W].a) * 64'(INV_GAIN_Q30);
      fa_pb_q <= 64'(aw[POS_W].b) * 64'(INV_GAIN_Q30);
    end
  end

  // fold to [-pi/2, pi/2], negating the vector when folded by pi
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      if (fa_t_q > HALF_PI_T) begin
        fb_t_q   <= fa_t_q - PI_T;
        fb_neg_q <= 1'b1;
      end else if (fa_t_q < -HALF_PI_T) begin
        fb_t_q   <= fa_t_q + PI_T;
        fb_neg_q <= 1'b1;
      end else begin
        fb_t_q   <= fa_t_q;
        fb_neg_q <= 1'b0;
      end
      fb_x_q <= XY_W'(fa_pa_q >>> 22);
      fb_y_q <= XY_W'(fa_pb_q >>> 22);
    end
  end

  // round the angle to q16, half away from zero
  assign t_abs = (fb_t_q < 0) ? -fb_t_q : fb_t_q;
  assign t_rnd = (t_abs + 37'sh8000) >>> 16;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      rw[0].z <= Z_W'((fb_t_q < 0) ? -t_rnd : t_rnd);
      rw[0].x <= fb_neg_q ? -fb_x_q : fb_x_q;
      rw[0].y <= fb_neg_q ? -fb_y_q : fb_y_q;
    end
  end

  // cordic cells
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    rpr_cordic_cell #(.STEP(i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (pipe_en),
      .vld_i  (rvld[i]),
      .word_i (rw[i]),
      .vld_o  (rvld[i+1]),
      .word_o (rw[i+1])
    );
  end

  // drop the guard bits with rounding and saturate
  function automatic logic [VAL_W-1:0] finish(input logic signed [XY_W-1:0] x);
    logic signed [XY_W:0]   xr;
    logic signed [XY_W-8:0] sh;
    logic [VAL_W-1:0]       r;
    xr = (XY_W+1)'(x) + (XY_W+1)'(128);
    sh = xr[XY_W:8];
    if (sh > (XY_W-7)'(64'sh7FFFFFFF)) begin
      r = 32'h7FFFFFFF;
    end else if (sh < (XY_W-7)'(-64'sh80000000)) begin
      r = 32'h80000000;
    end else begin
      r = sh[VAL_W-1:0];
    end
    return r;
  endfunction

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (pipe_en) begin
      out_vld_q <= rvld[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_first_q  <= finish(rw[CORDIC_STEPS].x);
      out_second_q <= finish(rw[CORDIC_STEPS].y);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_second_q, out_first_q};

  // a rebuild starts right after a write, so no word may enter next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready)
    else $error("word accepted while frequency table rebuilds");

  // reduced angle leaving the last angle cell stays below 2*pi
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    avld[POS_W] |-> (aw[POS_W].acc < TWO_PI_Q32))
    else $error("angle reduction out of range");

  // folded angle fed to the cordic stays within pi/2
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvld[0] |-> (rw[0].z <= Z_LIMIT && rw[0].z >= -Z_LIMIT))
    else $error("folded angle beyond pi/2");

  // a word leaving the last cordic cell reaches the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pipe_en && rvld[CORDIC_STEPS]) |=> out_vld_q)
    else $error("result word lost before output");

endmodule
